/* sv/psh_pkg.sv */
// Package for the polynomial string hash block: payload structs, register
// indexes, reset values and the sequencer state type. No dependencies.
`default_nettype none

package psh_pkg;

  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned HASH_W    = 16;
  localparam int unsigned BASE_W    = 16;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TABLE_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HASH_BASE  = 1'b1;

  // Configuration reset values
  localparam logic [CFG_W-1:0] TABLE_SIZE_RST = 16'd16;
  localparam logic [CFG_W-1:0] HASH_BASE_RST  = 16'd10;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              last_char;
  } psh_in_t;

  typedef struct packed {
    logic [HASH_W-1:0] hash_value;
    logic              key_done;
  } psh_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RED_TERM,
    ST_RED_SUM,
    ST_RED_POW,
    ST_EMIT
  } psh_state_e;

endpackage

`default_nettype wire

/* sv/psh_modred.sv */
// Shared shift-subtract reducer: remainder of a left-aligned dividend modulo
// a runtime modulus, one dividend bit per cycle. No package dependency.
`default_nettype none

module psh_modred #(
  parameter int unsigned MW = 16,
  parameter int unsigned DW = 32,
  parameter int unsigned CW = 6
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [CW-1:0] len_i,
  input  wire logic [DW-1:0] dividend_i,
  input  wire logic [MW-1:0] mod_i,
  output logic               done_o,
  output logic [MW-1:0]      rem_o
);

  logic          busy_q;
  logic [CW-1:0] cnt_q;
  logic          done_q;
  logic [DW-1:0] div_q;
  logic [MW-1:0] rem_q;

  logic [MW:0]   trial;
  logic [MW:0]   diff;
  logic [MW-1:0] rem_step;

  // Bring down the next dividend bit; subtract once if the partial remainder
  // reaches the modulus. It stays below the modulus after every step.
  assign trial    = {rem_q, div_q[DW-1]};
  assign diff     = trial - {1'b0, mod_i};
  assign rem_step = (trial >= {1'b0, mod_i}) ? diff[MW-1:0] : trial[MW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && (cnt_q == CW'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= len_i;
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      div_q <= {div_q[DW-2:0], 1'b0};
      rem_q <= rem_step;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

/* sv/polynomial_string_hash_mod.sv */
// Top level of the polynomial string hash: configuration registers, hash
// state, one shared multiplier, sequencer. Uses psh_pkg and psh_modred.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+---------------------------
//  in      | to block  | in_valid_i / in_stall_o    | psh_in_t  (char, last)
//  out     | from blk  | out_valid_o / out_stall_i  | psh_out_t (hash, done)
//  cfg     | to block  | cfg_valid_i / cfg_ready_o  | cfg_idx_i, cfg_data_i
//
//  The shared reducer clears one dividend bit a cycle over three reductions
//  (MW+8, MW+1 and MW+16 bits) for term, sum and next power, with MW the
//  modulus width (min(MOD_BITS,16)). A new character is taken only once the
//  previous result has been written to the output register.
//  Reset is asynchronous and active low; it restores hash 0, power 1 and the
//  register defaults. A stalled result is held in the output register; the
//  block then waits before writing the next one.
`default_nettype none

module polynomial_string_hash_mod #(
  parameter int unsigned MOD_BITS = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire psh_pkg::psh_in_t                  in_data_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output psh_pkg::psh_out_t                      out_data_o,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [psh_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [psh_pkg::CFG_W-1:0]         cfg_data_i
);

  // Modulus width: table_size is only 16 bits wide
  localparam int unsigned MW = (MOD_BITS < psh_pkg::CFG_W) ? MOD_BITS : psh_pkg::CFG_W;
  localparam int unsigned DW = MW + psh_pkg::BASE_W;
  localparam int unsigned CW = $clog2(DW + 1);

  localparam logic [CW-1:0] LEN_TERM = CW'(MW + psh_pkg::CHAR_W);
  localparam logic [CW-1:0] LEN_SUM  = CW'(MW + 1);
  localparam logic [CW-1:0] LEN_POW  = CW'(DW);

  psh_pkg::psh_state_e     state_q, state_d;

  logic [psh_pkg::CFG_W-1:0] table_size_q;
  logic [psh_pkg::CFG_W-1:0] hash_base_q;
  logic [MW-1:0]             running_hash_q;
  logic [MW-1:0]             base_power_q;
  logic [MW-1:0]             hash_new_q;
  logic                      last_q;
  logic                      out_valid_q;
  psh_pkg::psh_out_t         out_data_q;

  logic [MW-1:0]             mod_raw;
  logic [MW-1:0]             modulus;
  logic [psh_pkg::BASE_W-1:0] mul_b;
  logic [DW-1:0]             prod;
  logic [MW:0]               sum;

  logic                      red_start;
  logic [CW-1:0]             red_len;
  logic [DW-1:0]             red_div;
  logic                      red_done;
  logic [MW-1:0]             red_rem;
  logic                      load_hash;
  logic                      load_out;

  // Modulus: low MW bits of table_size, a zero treated as one
  assign mod_raw = table_size_q[MW-1:0];
  assign modulus = (mod_raw == '0) ? MW'(1) : mod_raw;

  // Shared multiplier: power times character while idle, power times base later
  assign mul_b = (state_q == psh_pkg::ST_IDLE) ? psh_pkg::BASE_W'(in_data_i.char_code)
                                               : hash_base_q;
  assign prod  = DW'(base_power_q) * DW'(mul_b);

  // Running hash plus reduced term; may exceed the modulus, the hash itself after a table change
  assign sum = {1'b0, running_hash_q} + {1'b0, red_rem};

  psh_modred #(
    .MW (MW),
    .DW (DW),
    .CW (CW)
  ) u_modred (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (red_start),
    .len_i      (red_len),
    .dividend_i (red_div),
    .mod_i      (modulus),
    .done_o     (red_done),
    .rem_o      (red_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= psh_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Sequencer: term, sum, next power, then hand the result over
  always_comb begin
    state_d   = state_q;
    red_start = 1'b0;
    red_len   = LEN_TERM;
    red_div   = {prod[DW-psh_pkg::CHAR_W-1:0], {psh_pkg::CHAR_W{1'b0}}};
    load_hash = 1'b0;
    load_out  = 1'b0;
    unique case (state_q)
      psh_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          red_start = 1'b1;
          state_d   = psh_pkg::ST_RED_TERM;
        end
      end
      psh_pkg::ST_RED_TERM: begin
        red_len = LEN_SUM;
        red_div = {sum, {(DW - MW - 1){1'b0}}};
        if (red_done) begin
          red_start = 1'b1;
          state_d   = psh_pkg::ST_RED_SUM;
        end
      end
      psh_pkg::ST_RED_SUM: begin
        red_len = LEN_POW;
        red_div = prod;
        if (red_done) begin
          red_start = 1'b1;
          load_hash = 1'b1;
          state_d   = psh_pkg::ST_RED_POW;
        end
      end
      psh_pkg::ST_RED_POW: begin
        if (red_done) begin
          state_d = psh_pkg::ST_EMIT;
        end
      end
      psh_pkg::ST_EMIT: begin
        // Hold until the output register is free or being emptied
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = psh_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = psh_pkg::ST_IDLE;
      end
    endcase
  end

  // Hash state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_hash_q <= '0;
      base_power_q   <= MW'(1);
      out_valid_q    <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid_q <= 1'b1;
        if (last_q) begin
          running_hash_q <= '0;
          base_power_q   <= MW'(1);
        end else begin
          running_hash_q <= hash_new_q;
          base_power_q   <= red_rem;
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if ((state_q == psh_pkg::ST_IDLE) && in_valid_i) begin
      last_q <= in_data_i.last_char;
    end
    if (load_hash) begin
      hash_new_q <= red_rem;
    end
    if (load_out) begin
      out_data_q.hash_value <= psh_pkg::HASH_W'(hash_new_q);
      out_data_q.key_done   <= last_q;
    end
  end

  // Configuration registers; always ready
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_size_q <= psh_pkg::TABLE_SIZE_RST;
      hash_base_q  <= psh_pkg::HASH_BASE_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_i)
        psh_pkg::REG_TABLE_SIZE: table_size_q <= cfg_data_i;
        psh_pkg::REG_HASH_BASE:  hash_base_q  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != psh_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

/* sv/psh_checker.sv */
// Port-level checker for the polynomial string hash, bound to the top level.
// Uses psh_pkg for the payload types.
`default_nettype none

module psh_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_stall_o,
  input wire logic                          out_valid_o,
  input wire logic                          out_stall_i,
  input wire psh_pkg::psh_out_t             out_data_o
);

  // Busy after taking a character
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken while previous character still in progress");

  // A new result only appears while a character is in progress
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared with no character in progress");

  // No result in the cycle after a character is taken
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> !$rose(out_valid_o))
    else $error("result appeared too early");

  // Stalled result is held
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result dropped or changed");

endmodule

bind polynomial_string_hash_mod psh_checker u_psh_checker (.*);

`default_nettype wire

/* bench/polynomial_string_hash_mod_tb.sv */
// Self-checking bench for polynomial_string_hash_mod: streams key characters through
// the block under several modulus and base settings, predicts every running hash and
// checks each result in order. Depends on psh_pkg and the block's RTL only.

module polynomial_string_hash_mod_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MOD_BITS = 16;
  // Figure for the block's acceptance-to-result time, used to scale the waits below.
  localparam int unsigned DUT_LATENCY = 3 * MOD_BITS + 29;
  // Worst quiet spell in a correct run: one character's latency, plus the longest
  // receiver hold and the longest sender gap, plus the settle pause between
  // phases. Take that several times over.
  localparam int unsigned QUIET_LIMIT = 40 * DUT_LATENCY;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned PHASES = 10;
  localparam int unsigned PHASE_CHARS = 170;
  localparam logic [psh_pkg::CFG_W-1:0] MOD_MASK =
    (MOD_BITS >= psh_pkg::CFG_W) ? {psh_pkg::CFG_W{1'b1}}
                                 : psh_pkg::CFG_W'((32'd1 << MOD_BITS) - 32'd1);

  // Receiver stall behaviour, chosen afresh for each stretch of cycles
  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_COIN,
    STALL_HOLD,
    STALL_RARE
  } stall_mode_e;

  // Block ports; the inputs are driven to known values from time zero
  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          in_valid_i  = 1'b0;
  logic                          in_stall_o;
  psh_pkg::psh_in_t              in_data_i   = '0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  psh_pkg::psh_out_t             out_data_o;
  logic                          cfg_valid_i = 1'b0;
  logic                          cfg_ready_o;
  logic [psh_pkg::CFG_IDX_W-1:0] cfg_idx_i   = psh_pkg::REG_TABLE_SIZE;
  logic [psh_pkg::CFG_W-1:0]     cfg_data_i  = '0;

  // Characters waiting to be sent, and hashes waiting to come back
  psh_pkg::psh_in_t  key_chars[$];
  psh_pkg::psh_out_t hash_expect[$];

  // Shadow of the block's registers and hash state
  logic [psh_pkg::CFG_W-1:0]  mod_size  = psh_pkg::TABLE_SIZE_RST;
  logic [psh_pkg::CFG_W-1:0]  poly_base = psh_pkg::HASH_BASE_RST;
  logic [psh_pkg::HASH_W-1:0] hash_acc  = '0;
  logic [psh_pkg::HASH_W-1:0] power_acc = psh_pkg::HASH_W'(1);

  // Transactions seen at the last rising edge
  bit in_taken  = 1'b0;
  bit out_taken = 1'b0;
  bit cfg_taken = 1'b0;

  int unsigned idle_cycles    = 0;
  int unsigned mismatch_count = 0;
  int unsigned burst_left     = 1;
  int unsigned gap_left       = 0;
  int unsigned stall_left     = 0;
  stall_mode_e stall_mode     = STALL_NONE;

  polynomial_string_hash_mod #(
    .MOD_BITS(MOD_BITS)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Advance the running hash by one character and return the value the block
  // must report. A modulus of zero counts as one, so every hash is then zero.
  // Closing a key puts the hash back to 0 and the power back to 1.
  function automatic psh_pkg::psh_out_t hash_char(psh_pkg::psh_in_t ch);
    logic [31:0]       modulus;
    logic [31:0]       term;
    logic [31:0]       sum;
    logic [31:0]       next_pow;
    psh_pkg::psh_out_t res;
    modulus  = ((mod_size & MOD_MASK) == '0) ? 32'd1 : 32'(mod_size & MOD_MASK);
    term     = (32'(ch.char_code) * 32'(power_acc)) % modulus;
    sum      = (32'(hash_acc) + term) % modulus;
    next_pow = (32'(power_acc) * 32'(poly_base)) % modulus;
    res.hash_value = sum[psh_pkg::HASH_W-1:0];
    res.key_done   = ch.last_char;
    if (ch.last_char) begin
      hash_acc  = '0;
      power_acc = psh_pkg::HASH_W'(1);
    end else begin
      hash_acc  = sum[psh_pkg::HASH_W-1:0];
      power_acc = next_pow[psh_pkg::HASH_W-1:0];
    end
    return res;
  endfunction

  task automatic flag_mismatch(string what, int unsigned got, int unsigned want);
    $display("%0t: mismatch in %0s: got %0d, expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic push_char(logic [psh_pkg::CHAR_W-1:0] code, logic last);
    psh_pkg::psh_in_t ch;
    ch.char_code = code;
    ch.last_char = last;
    key_chars.push_back(ch);
  endtask

  // Queue one key of random characters; leave it open when closed is clear.
  // A zero byte turns up now and then, as it still advances the power.
  task automatic push_key(int unsigned len, bit closed);
    logic [psh_pkg::CHAR_W-1:0] code;
    for (int unsigned k = 0; k < len; k++) begin
      code = ($urandom_range(0, 23) == 0) ? '0
                                          : psh_pkg::CHAR_W'($urandom_range(1, 255));
      push_char(code, closed && (k == len - 1));
    end
  endtask

  // Write one register; the shadow copy is updated by the monitor at the edge.
  task automatic write_reg(logic [psh_pkg::CFG_IDX_W-1:0] idx,
                           logic [psh_pkg::CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_idx_i   <= idx;
    cfg_data_i  <= data;
    cfg_valid_i <= 1'b1;
    do @(negedge clk_i); while (!cfg_taken);
    cfg_valid_i <= 1'b0;
  endtask

  // Hold until every queued character has gone in and every hash has come out.
  task automatic wait_drained();
    while (key_chars.size() != 0 || in_valid_i || hash_expect.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Monitor: sample at the rising edge, before the block's registers move.
  // Check the result first, then predict for a newly accepted character; a
  // character's own result never arrives at its acceptance edge.
  always @(posedge clk_i) begin : monitor
    psh_pkg::psh_out_t want;
    in_taken  = rst_ni && in_valid_i && !in_stall_o;
    out_taken = rst_ni && out_valid_o && !out_stall_i;
    cfg_taken = rst_ni && cfg_valid_i && cfg_ready_o;
    if (in_taken || out_taken || cfg_taken) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (out_taken) begin
      if (hash_expect.size() == 0) begin
        flag_mismatch("unexpected result hash", 32'(out_data_o.hash_value), 0);
      end else begin
        want = hash_expect.pop_front();
        if (out_data_o.hash_value !== want.hash_value)
          flag_mismatch("hash_value", 32'(out_data_o.hash_value), 32'(want.hash_value));
        if (out_data_o.key_done !== want.key_done)
          flag_mismatch("key_done", 32'(out_data_o.key_done), 32'(want.key_done));
      end
    end
    if (cfg_taken) begin
      if (cfg_idx_i == psh_pkg::REG_TABLE_SIZE) begin
        mod_size = cfg_data_i;
      end else if (cfg_idx_i == psh_pkg::REG_HASH_BASE) begin
        poly_base = cfg_data_i;
      end
    end
    if (in_taken) begin
      hash_expect.push_back(hash_char(in_data_i));
    end
  end

  // Driver: change inputs at the falling edge. Hold a stalled transaction;
  // otherwise send in bursts of random length with random gaps, some bursts
  // running straight into the next with no gap at all.
  always @(negedge clk_i) begin : driver
    if (rst_ni && !(in_valid_i && !in_taken)) begin
      if (gap_left != 0) begin
        in_valid_i <= 1'b0;
        gap_left--;
      end else if (key_chars.size() != 0) begin
        in_valid_i <= 1'b1;
        in_data_i  <= key_chars.pop_front();
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 40);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver stall pattern: stretches of no stall, coin-flip stalls, solid
  // holds and rare stalls, each of random length.
  always @(negedge clk_i) begin : stall_pattern
    if (stall_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      stall_left = (stall_mode == STALL_HOLD) ? $urandom_range(5, 150)
                                              : $urandom_range(20, 400);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      STALL_NONE: begin
        out_stall_i <= 1'b0;
      end
      STALL_COIN: begin
        out_stall_i <= 1'($urandom_range(0, 1));
      end
      STALL_HOLD: begin
        out_stall_i <= 1'b1;
      end
      default: begin
        out_stall_i <= ($urandom_range(0, 7) == 0);
      end
    endcase
  end

  // End the run when no transaction of any kind has happened for too long.
  initial begin : watchdog
    do @(posedge clk_i); while (idle_cycles < QUIET_LIMIT);
    $display("%0t: no transaction for %0d cycles", $realtime, QUIET_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    logic [psh_pkg::CFG_W-1:0] fixed_sizes [7];
    logic [psh_pkg::CFG_W-1:0] fixed_bases [7];
    logic [psh_pkg::CFG_W-1:0] size_now;
    logic [psh_pkg::CFG_W-1:0] base_now;
    int unsigned               sent;
    int unsigned               len;
    int unsigned               pick;
    // Zero modulus first, then the extremes, then ordinary settings
    fixed_sizes = '{16'd0, 16'd1, 16'hFFFF, 16'd2, 16'd65521, 16'd256,
                    psh_pkg::TABLE_SIZE_RST};
    fixed_bases = '{16'hFFFF, 16'd0, 16'hFFFF, 16'd1, 16'd31, 16'd2,
                    psh_pkg::HASH_BASE_RST};

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed keys at the reset settings: largest byte as a one-character
    // key, smallest byte, a zero byte inside a key, a short text key, a run
    // of largest bytes, and finally a key left open so that the first
    // register write lands in the middle of it.
    push_char(8'hFF, 1'b1);
    push_char(8'h01, 1'b1);
    push_char(8'h01, 1'b0);
    push_char(8'h00, 1'b0);
    push_char(8'h80, 1'b1);
    push_char(8'h61, 1'b0);
    push_char(8'h62, 1'b0);
    push_char(8'h63, 1'b1);
    repeat (4) push_char(8'hFF, 1'b0);
    push_char(8'hFF, 1'b1);
    push_char(8'h55, 1'b0);
    push_char(8'hAA, 1'b0);
    wait_drained();

    // Random phases: write both registers, then stream well-formed keys of
    // random length; about half the phases stop in the middle of a key.
    for (int unsigned p = 0; p < PHASES; p++) begin
      if (p < 7) begin
        size_now = fixed_sizes[p];
        base_now = fixed_bases[p];
      end else begin
        size_now = psh_pkg::CFG_W'($urandom_range(1, 65535));
        base_now = psh_pkg::CFG_W'($urandom_range(0, 65535));
      end
      if (p[0]) begin
        write_reg(psh_pkg::REG_HASH_BASE, base_now);
        write_reg(psh_pkg::REG_TABLE_SIZE, size_now);
      end else begin
        write_reg(psh_pkg::REG_TABLE_SIZE, size_now);
        write_reg(psh_pkg::REG_HASH_BASE, base_now);
      end
      sent = 0;
      while (sent < PHASE_CHARS) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          len = $urandom_range(1, 8);
        end else if (pick < 95) begin
          len = $urandom_range(9, 24);
        end else begin
          len = $urandom_range(25, 60);
        end
        push_key(len, 1'b1);
        sent += len;
      end
      if ($urandom_range(0, 1) == 1) begin
        push_key($urandom_range(1, 6), 1'b0);
      end
      wait_drained();
    end

    // Let any stray result show itself before deciding
    repeat (2 * DUT_LATENCY) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/psh_pkg.sv
sv/psh_modred.sv
sv/polynomial_string_hash_mod.sv
sv/psh_checker.sv
bench/polynomial_string_hash_mod_tb.sv
